// ----- hw/rtl/acl_pkg.sv -----
// Package for the associative cache: transfer structs, scan and update structs,
// state codes and helpers. No dependencies.
`default_nettype none
package acl_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int KEY_W = 64;
  localparam int VAL_W = 16;
  localparam int CNT_W = 32;
  localparam int ADDR_W = 1;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;
  localparam logic [ADDR_W-1:0] REG_POLICY = '0;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] step_value;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] hit_total;
  } rsp_t;

  typedef struct packed {
    logic             hit;
    logic             free;
    logic [VAL_W-1:0] hit_value;
    logic [CNT_W-1:0] metric;
  } scan_t;

  typedef struct packed {
    logic             wr;
    logic             upd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] stamp;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/acl_cell.sv -----
// One cache entry with its stage of the search and victim scan.
// Depends on acl_pkg.
`default_nettype none
module acl_cell #(
  parameter int IW = 8,
  parameter int CELL_IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      policy,
  input  wire logic [acl_pkg::KEY_W-1:0] key,
  input  wire acl_pkg::cmd_t             cmd,
  input  wire logic [IW-1:0]             cmd_idx,
  input  wire acl_pkg::scan_t            scan_in,
  input  wire logic [IW-1:0]             hit_idx_in,
  input  wire logic [IW-1:0]             free_idx_in,
  input  wire logic [IW-1:0]             best_idx_in,
  output acl_pkg::scan_t                 scan_out,
  output logic [IW-1:0]                  hit_idx_out,
  output logic [IW-1:0]                  free_idx_out,
  output logic [IW-1:0]                  best_idx_out
);

  logic                      valid;
  logic [acl_pkg::KEY_W-1:0] ekey;
  logic [acl_pkg::VAL_W-1:0] evalue;
  logic [acl_pkg::CNT_W-1:0] euse;
  logic [acl_pkg::CNT_W-1:0] elast;
  logic [acl_pkg::CNT_W-1:0] metric;
  logic [IW-1:0]             me;
  logic                      sel;
  acl_pkg::scan_t            scan_next;
  logic [IW-1:0]             hit_idx_next;
  logic [IW-1:0]             free_idx_next;
  logic [IW-1:0]             best_idx_next;

  assign me = IW'(CELL_IDX);
  assign sel = (cmd_idx == me);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.wr && sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && sel) begin
      ekey   <= cmd.key;
      evalue <= cmd.value;
      euse   <= acl_pkg::CNT_W'(1);
      elast  <= cmd.stamp;
    end else if (cmd.upd && sel) begin
      euse  <= acl_pkg::sat_inc(euse);
      elast <= cmd.stamp;
    end
  end

  always_comb begin
    metric = (policy == acl_pkg::POLICY_LFU) ? euse : elast;
    scan_next = scan_in;
    hit_idx_next = hit_idx_in;
    free_idx_next = free_idx_in;
    best_idx_next = best_idx_in;
    if (!scan_in.hit && valid && ekey == key) begin
      scan_next.hit = 1'b1;
      scan_next.hit_value = evalue;
      hit_idx_next = me;
    end
    if (!scan_in.free && !valid) begin
      scan_next.free = 1'b1;
      free_idx_next = me;
    end
    if (CELL_IDX == 0 || metric < scan_in.metric) begin
      scan_next.metric = metric;
      best_idx_next = me;
    end
  end

  always_ff @(posedge clk) begin
    scan_out     <= scan_next;
    hit_idx_out  <= hit_idx_next;
    free_idx_out <= free_idx_next;
    best_idx_out <= best_idx_next;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/assoc_cache_lru_lfu_top.sv -----
// Fully associative cache with LRU or LFU replacement: a chain of entry cells
// scanned one cell per cycle. A new request is stalled until the current one
// has been scanned through the cell chain and its response has been
// registered. Reset clears entry valid bits, access time, hit count and policy
// at once; no clearing pass.
`default_nettype none
module assoc_cache_lru_lfu_top #(
  parameter int ENTRIES = acl_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire acl_pkg::req_t              req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output acl_pkg::rsp_t                   rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [acl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  acl_pkg::state_t           state, state_next;
  logic [IW-1:0]             count, count_next;
  acl_pkg::req_t             item;
  logic                      policy;
  logic [acl_pkg::CNT_W-1:0] access_time, access_time_next;
  logic [acl_pkg::CNT_W-1:0] hit_counter, hit_counter_next;
  acl_pkg::rsp_t             rsp_next;
  logic                      rsp_valid_next;
  acl_pkg::cmd_t             cmd;
  logic [IW-1:0]             cmd_idx;
  logic                      go;

  acl_pkg::scan_t scan [ENTRIES];
  logic [IW-1:0]  hidx [ENTRIES];
  logic [IW-1:0]  fidx [ENTRIES];
  logic [IW-1:0]  bidx [ENTRIES];

  assign pready = 1'b1;
  assign prdata = (paddr == acl_pkg::REG_POLICY) ? {31'd0, policy} : 32'd0;
  assign req_stall = (state != acl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= acl_pkg::POLICY_LRU;
    end else if (psel && penable && pwrite && pready && paddr == acl_pkg::REG_POLICY) begin
      policy <= pwdata[0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        acl_cell #(.IW(IW), .CELL_IDX(g)) u_cell (
          .clk(clk), .rst(rst), .policy(policy), .key(item.lookup_key),
          .cmd(cmd), .cmd_idx(cmd_idx),
          .scan_in('0), .hit_idx_in('0), .free_idx_in('0), .best_idx_in('0),
          .scan_out(scan[g]), .hit_idx_out(hidx[g]),
          .free_idx_out(fidx[g]), .best_idx_out(bidx[g])
        );
      end else begin : g_body
        acl_cell #(.IW(IW), .CELL_IDX(g)) u_cell (
          .clk(clk), .rst(rst), .policy(policy), .key(item.lookup_key),
          .cmd(cmd), .cmd_idx(cmd_idx),
          .scan_in(scan[g-1]), .hit_idx_in(hidx[g-1]),
          .free_idx_in(fidx[g-1]), .best_idx_in(bidx[g-1]),
          .scan_out(scan[g]), .hit_idx_out(hidx[g]),
          .free_idx_out(fidx[g]), .best_idx_out(bidx[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= acl_pkg::ST_IDLE;
      count       <= '0;
      access_time <= '0;
      hit_counter <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      access_time <= access_time_next;
      hit_counter <= hit_counter_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
    if (go) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    access_time_next = access_time;
    hit_counter_next = hit_counter;
    rsp_valid_next = rsp_valid && rsp_stall;
    go = 1'b0;
    cmd = '0;
    cmd_idx = '0;
    rsp_next = '0;
    unique case (state)
      acl_pkg::ST_IDLE: begin
        if (req_valid) begin
          count_next = '0;
          state_next = acl_pkg::ST_SCAN;
        end
      end
      acl_pkg::ST_SCAN: begin
        count_next = count + IW'(1);
        if (count == IW'(ENTRIES - 1)) begin
          state_next = acl_pkg::ST_FINISH;
        end
      end
      acl_pkg::ST_FINISH: begin
        go = !rsp_valid || !rsp_stall;
        rsp_next.hit = scan[ENTRIES-1].hit;
        rsp_next.hit_total = hit_counter;
        if (item.mode == acl_pkg::MODE_LOOKUP) begin
          cmd.stamp = acl_pkg::sat_inc(access_time);
          if (scan[ENTRIES-1].hit) begin
            cmd.upd = go;
            cmd_idx = hidx[ENTRIES-1];
            rsp_next.found_value = scan[ENTRIES-1].hit_value;
            rsp_next.hit_total = acl_pkg::sat_inc(hit_counter);
          end
        end else begin
          cmd.stamp = access_time;
          cmd.wr = go && !scan[ENTRIES-1].hit;
          cmd.key = item.lookup_key;
          cmd.value = item.step_value;
          cmd_idx = scan[ENTRIES-1].free ? fidx[ENTRIES-1] : bidx[ENTRIES-1];
        end
        if (go) begin
          access_time_next = cmd.stamp;
          hit_counter_next = rsp_next.hit_total;
          rsp_valid_next = 1'b1;
          state_next = acl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = acl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
